FILE: rtl/sxu_pkg.sv
// Shared types and constants of the subset execute unit.
// Holds the command and status codes and the stage-1 result bundle; no dependencies.
`default_nettype none

package sxu_pkg;

  localparam int unsigned Xlen     = 32;
  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegAw    = $clog2(NumRegs);
  localparam int unsigned MemWords = 1024;
  localparam int unsigned MemAw    = $clog2(MemWords);

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_AND  = 4'd2,
    CMD_OR   = 4'd3,
    CMD_ADDI = 4'd4,
    CMD_LW   = 4'd5,
    CMD_SW   = 4'd6,
    CMD_BEQ  = 4'd7,
    CMD_BNE  = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNSUP = 2'd2
  } status_e;

  // Everything the execute stage decides for one word.
  typedef struct packed {
    status_e          status;
    logic [Xlen-1:0]  next_pc;
    logic             taken;
    logic             to_reg;
    logic [Xlen-1:0]  result;
    logic             mem_rd;
    logic             mem_wr;
    logic [MemAw-1:0] idx;
  } exec_t;

endpackage

`default_nettype wire

FILE: rtl/sxu_regfile.sv
// Register file: 32 x 32 memory, two registered read ports, one write port.
// Per-entry valid bits give the all-zero reset; depends on sxu_pkg.
`default_nettype none

module sxu_regfile
  import sxu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [RegAw-1:0] ra1_i,
  input  wire logic [RegAw-1:0] ra2_i,
  output logic      [Xlen-1:0]  rd1_o,
  output logic      [Xlen-1:0]  rd2_o,
  input  wire logic             we_i,
  input  wire logic [RegAw-1:0] wa_i,
  input  wire logic [Xlen-1:0]  wd_i
);

  logic [Xlen-1:0]    mem_q [NumRegs];
  logic [NumRegs-1:0] valid_q;
  logic [Xlen-1:0]    rd1_q, rd2_q;
  logic               rv1_q, rv2_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    if (rd_en_i) begin
      rd1_q <= mem_q[ra1_i];
      rd2_q <= mem_q[ra2_i];
    end
  end

  // x0 is never written, so its valid bit stays low and it reads zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv1_q   <= 1'b0;
      rv2_q   <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wa_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rv1_q <= valid_q[ra1_i];
        rv2_q <= valid_q[ra2_i];
      end
    end
  end

  assign rd1_o = rv1_q ? rd1_q : '0;
  assign rd2_o = rv2_q ? rd2_q : '0;

endmodule

`default_nettype wire

FILE: rtl/sxu_dmem.sv
// Data memory: MemWords x 32 words, one write port, one registered read port.
// Runs a zero-fill sweep after reset; depends on sxu_pkg.
`default_nettype none

module sxu_dmem
  import sxu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [MemAw-1:0] raddr_i,
  output logic      [Xlen-1:0]  rdata_o,
  input  wire logic             we_i,
  input  wire logic [MemAw-1:0] waddr_i,
  input  wire logic [Xlen-1:0]  wdata_i,
  output logic                  clearing_o
);

  logic [Xlen-1:0]  mem_q [MemWords];
  logic [Xlen-1:0]  rdata_q;
  logic             clearing_q, clearing_d;
  logic [MemAw-1:0] clr_addr_q, clr_addr_d;
  logic             wr_en;
  logic [MemAw-1:0] wr_addr;
  logic [Xlen-1:0]  wr_data;

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + MemAw'(1);
      if (clr_addr_q == MemAw'(MemWords - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Sweep owns the write port until every word holds zero.
  assign wr_en   = clearing_q || we_i;
  assign wr_addr = clearing_q ? clr_addr_q : waddr_i;
  assign wr_data = clearing_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

`default_nettype wire

FILE: rtl/sxu_exec.sv
// Execute logic: ALU, load/store address and range check, branch and pc update.
// Pure combinational; depends on sxu_pkg.
`default_nettype none

module sxu_exec
  import sxu_pkg::*;
(
  input  wire logic [3:0]       cmd_i,
  input  wire logic [12:0]      imm_i,
  input  wire logic [Xlen-1:0]  a_i,
  input  wire logic [Xlen-1:0]  b_i,
  input  wire logic [Xlen-1:0]  pc_i,
  output exec_t                 ex_o
);

  logic [Xlen-1:0] imm32;
  logic [Xlen-1:0] sum;
  logic            in_rng;
  logic [12:0]     bsum;
  logic [Xlen-1:0] boff;

  assign imm32 = {{(Xlen-13){imm_i[12]}}, imm_i};
  assign sum   = a_i + imm32;

  // Byte addresses -1..-3 truncate to word 0; other negatives are out of range.
  assign in_rng = (!sum[Xlen-1] && (sum[Xlen-1:2] < (Xlen-2)'(MemWords))) ||
                  (sum[Xlen-1] && (&sum[Xlen-2:2]) && (sum[1:0] != 2'b00));

  // Bias negatives by 3 so the arithmetic shift truncates toward zero.
  assign bsum = imm_i + {11'd0, {2{imm_i[12]}}};
  assign boff = {{(Xlen-11){bsum[12]}}, bsum[12:2]};

  always_comb begin
    ex_o         = '0;
    ex_o.status  = ST_OK;
    ex_o.next_pc = pc_i + Xlen'(1);
    ex_o.idx     = sum[Xlen-1] ? '0 : sum[MemAw+1:2];
    case (cmd_i)
      CMD_ADD: begin
        ex_o.result = a_i + b_i;
        ex_o.to_reg = 1'b1;
      end
      CMD_SUB: begin
        ex_o.result = a_i - b_i;
        ex_o.to_reg = 1'b1;
      end
      CMD_AND: begin
        ex_o.result = a_i & b_i;
        ex_o.to_reg = 1'b1;
      end
      CMD_OR: begin
        ex_o.result = a_i | b_i;
        ex_o.to_reg = 1'b1;
      end
      CMD_ADDI: begin
        ex_o.result = sum;
        ex_o.to_reg = 1'b1;
      end
      CMD_LW: begin
        if (in_rng) begin
          ex_o.mem_rd = 1'b1;
          ex_o.to_reg = 1'b1;
        end else begin
          ex_o.status = ST_RANGE;
        end
      end
      CMD_SW: begin
        if (in_rng) begin
          ex_o.mem_wr = 1'b1;
        end else begin
          ex_o.status = ST_RANGE;
        end
      end
      CMD_BEQ: begin
        if (a_i == b_i) begin
          ex_o.taken   = 1'b1;
          ex_o.next_pc = pc_i + boff;
        end
      end
      CMD_BNE: begin
        if (a_i != b_i) begin
          ex_o.taken   = 1'b1;
          ex_o.next_pc = pc_i + boff;
        end
      end
      default: begin
        ex_o.status = ST_UNSUP;
      end
    endcase
    if (ex_o.status != ST_OK) begin
      ex_o.next_pc = pc_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/riscv_subset_execute_unit.sv
// Execute unit for a small RV32I subset: add, sub, and, or, addi, lw, sw, beq, bne.
// Uses sxu_pkg, sxu_regfile, sxu_dmem and sxu_exec.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one decoded instruction word:
//   cmd, dest/src register indexes and a 13-bit signed immediate. Output channel
//   (out_valid_o / out_stall_i) returns one result word per instruction: status,
//   next pc in words, branch flag, register-write flag and the written value.
//   A word moves at a rising edge with valid high and stall low.
// Timing:
//   Three stages: register-file read, execute (ALU, address, branch, memory
//   access), write-back into the output register. A result passes the stage-1,
//   stage-2 and output registers in order; one instruction is taken every cycle
//   while in_stall_o is low. Operands come from the synchronous register
//   file with forwarding from the two words ahead; dependent words go back to back.
// Reset:
//   Registers and pc clear at once. Data memory is zero-filled by a sweep of
//   all MemWords words (1024) after reset; in_stall_o stays high during it.
// Backpressure:
//   While the output holds a word and out_stall_i is high, the whole pipeline
//   holds and in_stall_o rises; nothing is lost or repeated.
`default_nettype none

module riscv_subset_execute_unit
  import sxu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [3:0]        cmd_i,
  input  wire logic [4:0]        dest_reg_i,
  input  wire logic [4:0]        src1_reg_i,
  input  wire logic [4:0]        src2_reg_i,
  input  wire logic signed [12:0] immediate_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [1:0]        status_o,
  output logic signed [31:0]     next_pc_o,
  output logic                   branch_taken_o,
  output logic                   reg_written_o,
  output logic signed [31:0]     written_value_o
);

  // Pipeline control: every stage advances together unless the output is stuck.
  logic adv;
  logic in_acc;
  logic clearing;

  // Stage 1: instruction fields while the register file read completes.
  logic             s1_v_q;
  logic [3:0]       s1_cmd_q;
  logic [RegAw-1:0] s1_rd_q, s1_rs1_q, s1_rs2_q;
  logic [12:0]      s1_imm_q;

  // Stage 2: executed result waiting on the data memory read.
  logic             s2_v_q;
  status_e          s2_status_q;
  logic [Xlen-1:0]  s2_pc_q;
  logic             s2_taken_q, s2_wrote_q, s2_lw_q;
  logic [RegAw-1:0] s2_rd_q;
  logic [Xlen-1:0]  s2_val_q;
  logic [Xlen-1:0]  s2_final;

  // Last register write, covering the read that raced it in the memory.
  logic             wb_v_q;
  logic [RegAw-1:0] wb_rd_q;
  logic [Xlen-1:0]  wb_val_q;

  // Output register.
  logic             out_v_q;
  status_e          out_status_q;
  logic [Xlen-1:0]  out_pc_q, out_val_q;
  logic             out_taken_q, out_wrote_q;

  logic [Xlen-1:0]  pc_q;
  logic [Xlen-1:0]  rf_rd1, rf_rd2, op_a, op_b;
  logic [Xlen-1:0]  dm_rdata;
  logic             rf_we, dm_we;
  logic             s1_wrote;
  logic [Xlen-1:0]  s1_val;
  exec_t            ex;

  assign adv        = !out_v_q || !out_stall_i;
  assign in_stall_o = clearing || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  sxu_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (adv),
    .ra1_i   (src1_reg_i),
    .ra2_i   (src2_reg_i),
    .rd1_o   (rf_rd1),
    .rd2_o   (rf_rd2),
    .we_i    (rf_we),
    .wa_i    (s2_rd_q),
    .wd_i    (s2_final)
  );

  // Forward the newest pending write first.
  assign s2_final = s2_lw_q ? dm_rdata : s2_val_q;

  always_comb begin
    op_a = rf_rd1;
    if (s2_v_q && s2_wrote_q && (s2_rd_q == s1_rs1_q)) begin
      op_a = s2_final;
    end else if (wb_v_q && (wb_rd_q == s1_rs1_q)) begin
      op_a = wb_val_q;
    end
    op_b = rf_rd2;
    if (s2_v_q && s2_wrote_q && (s2_rd_q == s1_rs2_q)) begin
      op_b = s2_final;
    end else if (wb_v_q && (wb_rd_q == s1_rs2_q)) begin
      op_b = wb_val_q;
    end
  end

  sxu_exec u_exec (
    .cmd_i (s1_cmd_q),
    .imm_i (s1_imm_q),
    .a_i   (op_a),
    .b_i   (op_b),
    .pc_i  (pc_q),
    .ex_o  (ex)
  );

  // Writes to x0 drop; failed instructions write nothing.
  assign s1_wrote = ex.to_reg && (s1_rd_q != '0);
  assign s1_val   = s1_wrote ? ex.result : (ex.mem_wr ? op_b : '0);
  assign dm_we    = adv && s1_v_q && ex.mem_wr;
  assign rf_we    = adv && s2_v_q && s2_wrote_q;

  sxu_dmem u_dmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (adv),
    .raddr_i    (ex.idx),
    .rdata_o    (dm_rdata),
    .we_i       (dm_we),
    .waddr_i    (ex.idx),
    .wdata_i    (op_b),
    .clearing_o (clearing)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      wb_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      pc_q    <= '0;
    end else if (adv) begin
      s1_v_q  <= in_acc;
      s2_v_q  <= s1_v_q;
      wb_v_q  <= s2_v_q && s2_wrote_q;
      out_v_q <= s2_v_q;
      if (s1_v_q) begin
        pc_q <= ex.next_pc;
      end
    end
  end

  // Payload registers: hold while stalled, no reset.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_acc) begin
        s1_cmd_q <= cmd_i;
        s1_rd_q  <= dest_reg_i;
        s1_rs1_q <= src1_reg_i;
        s1_rs2_q <= src2_reg_i;
        s1_imm_q <= immediate_i;
      end
      if (s1_v_q) begin
        s2_status_q <= ex.status;
        s2_pc_q     <= ex.next_pc;
        s2_taken_q  <= ex.taken;
        s2_wrote_q  <= s1_wrote;
        s2_lw_q     <= s1_wrote && ex.mem_rd;
        s2_rd_q     <= s1_rd_q;
        s2_val_q    <= s1_val;
      end else begin
        s2_wrote_q <= 1'b0;
      end
      if (s2_v_q) begin
        wb_rd_q      <= s2_rd_q;
        wb_val_q     <= s2_final;
        out_status_q <= s2_status_q;
        out_pc_q     <= s2_pc_q;
        out_taken_q  <= s2_taken_q;
        out_wrote_q  <= s2_wrote_q;
        out_val_q    <= s2_final;
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign status_o        = out_status_q;
  assign next_pc_o       = out_pc_q;
  assign branch_taken_o  = out_taken_q;
  assign reg_written_o   = out_wrote_q;
  assign written_value_o = out_val_q;

`ifndef ASSERT_OFF
  // A failed instruction reports nothing but its status and the old pc.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |->
      (!reg_written_o && !branch_taken_o && (written_value_o == '0)))
    else $error("failed instruction left side effects in its result");

  // A held pipeline must not move the pc.
  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(pc_q))
    else $error("pc changed while the pipeline was held");

  // No store may reach memory while the zero-fill sweep runs.
  a_no_store_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dm_we |-> !clearing)
    else $error("store overlapped the memory clearing sweep");

  // x0 is never written.
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (s2_rd_q != '0))
    else $error("register write aimed at x0");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for riscv_subset_execute_unit: drives decoded instruction words and
// checks every result word against an in-bench model of registers, data memory and pc.
// Depends on sxu_pkg and the execute unit RTL only.
`default_nettype none

module tb;
  import sxu_pkg::*;

  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 12;
  localparam int NumRandom   = 1880;
  localparam int IdlePct     = 25;
  localparam int DrainCycles = 8;
  // Memory sweep, ~1900 words with sender gaps and receiver stalls, taken many times over.
  localparam int LimitCycles = 200000;

  // Command codes the unit does not implement.
  localparam logic [3:0] CmdRsvdLo = 4'd9;
  localparam logic [3:0] CmdRsvdHi = 4'd15;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [4:0]        rd;
    logic [4:0]        rs1;
    logic [4:0]        rs2;
    logic signed [12:0] imm;
  } instr_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] next_pc;
    logic        taken;
    logic        wrote;
    logic [31:0] wval;
  } outcome_t;

  typedef struct packed {
    instr_t   ins;
    logic     typed;
    outcome_t want;
  } dir_row_t;

  localparam outcome_t Untyped = '{ST_OK, 32'd0, 1'b0, 1'b0, 32'd0};

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [3:0]        cmd_i           = '0;
  logic [4:0]        dest_reg_i      = '0;
  logic [4:0]        src1_reg_i      = '0;
  logic [4:0]        src2_reg_i      = '0;
  logic signed [12:0] immediate_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic [1:0]        status_o;
  logic signed [31:0] next_pc_o;
  logic              branch_taken_o;
  logic              reg_written_o;
  logic signed [31:0] written_value_o;

  // Architectural state as the unit should see it after every accepted word.
  logic [31:0] gold_regs [NumRegs]  = '{default: '0};
  logic [31:0] gold_mem  [MemWords] = '{default: '0};
  logic [31:0] gold_pc              = '0;

  outcome_t pending_results [$];
  outcome_t head;
  int       mismatches = 0;
  bit       calm       = 1'b0;

  // Directed words start from the reset state: registers, memory and pc all zero.
  // Rows with typed=1 carry an outcome that is obvious from the instruction alone;
  // the rest take their expectation from the model below.
  localparam int NumDir = 25;
  dir_row_t dir_table [NumDir] = '{
    // add x1 = x0 + x0 right after reset
    '{'{CMD_ADD,  5'd1,  5'd0,  5'd0,  13'sd0},    1'b1, '{ST_OK, 32'd1, 1'b0, 1'b1, 32'd0}},
    // addi with the largest and the smallest immediate
    '{'{CMD_ADDI, 5'd1,  5'd0,  5'd0,  13'sd4095}, 1'b1,
      '{ST_OK, 32'd2, 1'b0, 1'b1, 32'h0000_0FFF}},
    '{'{CMD_ADDI, 5'd2,  5'd0,  5'd0,  13'h1000},  1'b1,
      '{ST_OK, 32'd3, 1'b0, 1'b1, 32'hFFFF_F000}},
    // write to x0 is dropped
    '{'{CMD_ADDI, 5'd0,  5'd1,  5'd0,  13'sd5},    1'b1, '{ST_OK, 32'd4, 1'b0, 1'b0, 32'd0}},
    // both ends of the unsupported code space: pc holds
    '{'{CmdRsvdLo, 5'd3, 5'd1,  5'd2,  13'sd7},    1'b1, '{ST_UNSUP, 32'd4, 1'b0, 1'b0, 32'd0}},
    '{'{CmdRsvdHi, 5'd31, 5'd31, 5'd31, -13'sd1},  1'b1, '{ST_UNSUP, 32'd4, 1'b0, 1'b0, 32'd0}},
    // load far below memory
    '{'{CMD_LW,   5'd3,  5'd2,  5'd0,  13'h1000},  1'b1, '{ST_RANGE, 32'd4, 1'b0, 1'b0, 32'd0}},
    // store to the last word, then read it back
    '{'{CMD_SW,   5'd31, 5'd0,  5'd1,  13'sd4095}, 1'b1,
      '{ST_OK, 32'd5, 1'b0, 1'b0, 32'h0000_0FFF}},
    '{'{CMD_LW,   5'd4,  5'd0,  5'd0,  13'sd4092}, 1'b1,
      '{ST_OK, 32'd6, 1'b0, 1'b1, 32'h0000_0FFF}},
    // small negative byte addresses fold onto word 0
    '{'{CMD_LW,   5'd5,  5'd0,  5'd0,  -13'sd3},   1'b1, '{ST_OK, 32'd7, 1'b0, 1'b1, 32'd0}},
    '{'{CMD_SW,   5'd9,  5'd0,  5'd2,  -13'sd1},   1'b1,
      '{ST_OK, 32'd8, 1'b0, 1'b0, 32'hFFFF_F000}},
    '{'{CMD_LW,   5'd6,  5'd0,  5'd0,  -13'sd2},   1'b1,
      '{ST_OK, 32'd9, 1'b0, 1'b1, 32'hFFFF_F000}},
    // byte -4 is word -1: out of range
    '{'{CMD_LW,   5'd7,  5'd0,  5'd0,  -13'sd4},   1'b1, '{ST_RANGE, 32'd9, 1'b0, 1'b0, 32'd0}},
    // byte 4096 is word MemWords: out of range
    '{'{CMD_SW,   5'd0,  5'd1,  5'd2,  13'sd1},    1'b1, '{ST_RANGE, 32'd9, 1'b0, 1'b0, 32'd0}},
    // load into x0 is dropped
    '{'{CMD_LW,   5'd0,  5'd0,  5'd0,  13'sd0},    1'b1, '{ST_OK, 32'd10, 1'b0, 1'b0, 32'd0}},
    '{'{CMD_SUB,  5'd8,  5'd0,  5'd1,  13'sd0},    1'b0, Untyped},
    '{'{CMD_AND,  5'd9,  5'd1,  5'd2,  13'sd0},    1'b0, Untyped},
    '{'{CMD_OR,   5'd10, 5'd1,  5'd2,  13'sd0},    1'b0, Untyped},
    '{'{CMD_ADD,  5'd11, 5'd2,  5'd2,  13'sd0},    1'b0, Untyped},
    // branches: taken backward, not taken, taken forward, not taken, taken by zero words
    '{'{CMD_BEQ,  5'd13, 5'd0,  5'd0,  13'h1000},  1'b0, Untyped},
    '{'{CMD_BEQ,  5'd13, 5'd1,  5'd0,  13'sd8},    1'b0, Untyped},
    '{'{CMD_BNE,  5'd13, 5'd1,  5'd0,  13'sd4095}, 1'b0, Untyped},
    '{'{CMD_BNE,  5'd13, 5'd0,  5'd0,  13'sd4},    1'b0, Untyped},
    '{'{CMD_BEQ,  5'd13, 5'd3,  5'd3,  -13'sd3},   1'b0, Untyped},
    '{'{CMD_SUB,  5'd12, 5'd2,  5'd1,  13'sd0},    1'b0, Untyped}
  };

  riscv_subset_execute_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .dest_reg_i     (dest_reg_i),
    .src1_reg_i     (src1_reg_i),
    .src2_reg_i     (src2_reg_i),
    .immediate_i    (immediate_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .next_pc_o      (next_pc_o),
    .branch_taken_o (branch_taken_o),
    .reg_written_o  (reg_written_o),
    .written_value_o(written_value_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Signed divide by 4, rounding toward zero.
  function automatic logic [31:0] words_from_bytes(logic [31:0] x);
    logic [31:0] mag;
    mag = x[31] ? -x : x;
    return x[31] ? -(mag >> 2) : (mag >> 2);
  endfunction

  // Execute one word on the model state and return the result the unit must give.
  function automatic outcome_t retire_instr(instr_t w);
    logic [31:0] a, b, imm, res, idx;
    logic        to_reg, in_mem;
    outcome_t    o;
    a        = gold_regs[w.rs1];
    b        = gold_regs[w.rs2];
    imm      = {{19{w.imm[12]}}, w.imm};
    res      = '0;
    to_reg   = 1'b0;
    idx      = words_from_bytes(a + imm);
    in_mem   = !idx[31] && (idx < MemWords);
    o.status  = ST_OK;
    o.next_pc = gold_pc + 32'd1;
    o.taken   = 1'b0;
    o.wrote   = 1'b0;
    o.wval    = '0;
    case (w.cmd)
      CMD_ADD: begin
        res = a + b;
        to_reg = 1'b1;
      end
      CMD_SUB: begin
        res = a - b;
        to_reg = 1'b1;
      end
      CMD_AND: begin
        res = a & b;
        to_reg = 1'b1;
      end
      CMD_OR: begin
        res = a | b;
        to_reg = 1'b1;
      end
      CMD_ADDI: begin
        res = a + imm;
        to_reg = 1'b1;
      end
      CMD_LW: begin
        if (in_mem) begin
          res = gold_mem[idx[MemAw-1:0]];
          to_reg = 1'b1;
        end else begin
          o.status = ST_RANGE;
        end
      end
      CMD_SW: begin
        if (in_mem) begin
          gold_mem[idx[MemAw-1:0]] = b;
          o.wval = b;
        end else begin
          o.status = ST_RANGE;
        end
      end
      CMD_BEQ, CMD_BNE: begin
        // beq wants equal operands, bne wants them different
        if ((w.cmd == CMD_BEQ) == (a == b)) begin
          o.taken   = 1'b1;
          o.next_pc = gold_pc + words_from_bytes(imm);
        end
      end
      default: begin
        o.status = ST_UNSUP;
      end
    endcase
    if (o.status != ST_OK) begin
      o.next_pc = gold_pc;
    end else if (to_reg && w.rd != '0) begin
      gold_regs[w.rd] = res;
      o.wrote = 1'b1;
      o.wval  = res;
    end
    gold_pc = o.next_pc;
    return o;
  endfunction

  // Draw the next random word. Most loads and stores are steered into memory,
  // reusing the drawn base register if it can reach the target, else x0; the rest are noise.
  function automatic instr_t pick_instr();
    instr_t      w;
    int unsigned roll;
    longint      tgt, off;
    w.rd  = 5'($urandom);
    w.rs1 = 5'($urandom);
    w.rs2 = 5'($urandom);
    w.imm = 13'($urandom);
    roll  = $urandom_range(99);
    if (roll < 35) begin
      w.cmd = 4'($urandom_range(CMD_OR));
    end else if (roll < 45) begin
      w.cmd = CMD_ADDI;
    end else if (roll < 85) begin
      w.cmd = ($urandom_range(1) != 0) ? CMD_LW : CMD_SW;
      if ($urandom_range(9) != 0) begin
        // favor a small window so loads often hit stored words
        if ($urandom_range(1) != 0) begin
          tgt = longint'($urandom_range(258)) - 3;
        end else begin
          tgt = longint'($urandom_range(MemWords * 4 + 2)) - 3;
        end
        off = tgt - longint'($signed(gold_regs[w.rs1]));
        if (off < -4096 || off > 4095) begin
          w.rs1 = '0;
          off   = tgt;
        end
        w.imm = 13'(off);
      end
    end else if (roll < 95) begin
      w.cmd = ($urandom_range(1) != 0) ? CMD_BEQ : CMD_BNE;
      if ($urandom_range(1) != 0) begin
        w.rs2 = w.rs1;
      end
    end else begin
      w.cmd = 4'($urandom_range(CmdRsvdHi, CmdRsvdLo));
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then queue its expected result.
  task automatic send_word(instr_t w, logic typed, outcome_t want);
    outcome_t o;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= w.cmd;
    dest_reg_i  <= w.rd;
    src1_reg_i  <= w.rs1;
    src2_reg_i  <= w.rs2;
    immediate_i <= w.imm;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    o = retire_instr(w);
    pending_results.push_back(typed ? want : o);
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", fname, want, got);
    end
  endtask

  // Result side: compare each taken word with the oldest expectation, then pick
  // the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result word with no instruction pending");
      end else begin
        head = pending_results.pop_front();
        check_field("status",        32'(head.status), 32'(status_o));
        check_field("next_pc",       head.next_pc,     next_pc_o);
        check_field("branch_taken",  32'(head.taken),  32'(branch_taken_o));
        check_field("reg_written",   32'(head.wrote),  32'(reg_written_o));
        check_field("written_value", head.wval,        written_value_o);
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  // Instruction side: reset, directed table, then random words.
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    // in_stall_o stays high through the memory sweep; the handshake absorbs it
    foreach (dir_table[i]) begin
      send_word(dir_table[i].ins, dir_table[i].typed, dir_table[i].want);
    end
    drain();
    for (int n = 0; n < NumRandom; n++) begin
      // a long stretch with no idling on either side
      calm = (n >= 700) && (n < 1100);
      if (n == 1300) begin
        drain();
      end
      send_word(pick_instr(), 1'b0, Untyped);
    end
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/sxu_pkg.sv
rtl/sxu_regfile.sv
rtl/sxu_dmem.sv
rtl/sxu_exec.sv
rtl/riscv_subset_execute_unit.sv
verif/tb.sv
